// File: rtl/twc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the triggered wave capture block.
// No dependencies.
package twc_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_RECORDING = 2'd1,
    ST_RECORDED  = 2'd2
  } slot_st_t;

  localparam int SLOTS_DEF       = 4;
  localparam int DEPTH_DEF       = 1024;
  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int WORD_W  = 16;
  localparam int POS_W   = 10;
  localparam int SLOT_W  = 2;
  localparam int CH_W    = 2;
  localparam int CNT_W   = 16;
  localparam int PTD_W   = 10;
  localparam int NUM_IN_CH = 4;

  localparam logic [PTD_W-1:0] PTD_RESET = 10'd160;

endpackage

// File: rtl/twc_store.sv
`timescale 1ns / 1ps
// Sample store: one row per slot and position, all channel words side by side.
// Single write port, single registered read port. Uses no package items.
module twc_store #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/triggered_wave_capture.sv
`timescale 1ns / 1ps
// Multi-slot circular waveform recorder with post-trigger stop.
// Depends on twc_pkg and twc_store.
//
// Usage:
//   Input beats carry a command: sample (writes all channel words at the
//   current write position of the current slot), trigger (arms the stop
//   position write position + cfg distance, modulo depth) or read (fetches
//   one stored word plus that slot's status). Every beat gives exactly one
//   output beat, in order.
//   From input accept to output, a beat passes the registered store read
//   (pending stage) and then the output register. A new beat can be taken
//   every cycle while the output is not stalled and no distance reduction
//   runs; the output register decouples the two sides, so when the receiver
//   stalls one more beat is absorbed before in_ready drops.
//   cfg_wr_en writes the post-trigger distance at once. After reset and after
//   each cfg write, in_ready stays low while the distance is reduced modulo
//   DEPTH, one subtraction per cycle; none is needed when DEPTH exceeds it.
//   Reset puts slot 0 in recording, the others empty, pointers to zero.
//   The store is not swept: a per-slot fill mark makes never-written
//   positions read as zero, so the block is ready right after reset.
module triggered_wave_capture #(
  parameter int SLOTS       = twc_pkg::SLOTS_DEF,
  parameter int DEPTH       = twc_pkg::DEPTH_DEF,
  parameter int CHANNELS    = twc_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = twc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [twc_pkg::PTD_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [twc_pkg::CMD_W-1:0]  in_cmd,
  input  logic [twc_pkg::WORD_W-1:0] in_sample_0,
  input  logic [twc_pkg::WORD_W-1:0] in_sample_1,
  input  logic [twc_pkg::WORD_W-1:0] in_sample_2,
  input  logic [twc_pkg::WORD_W-1:0] in_sample_3,
  input  logic [twc_pkg::SLOT_W-1:0] in_read_slot,
  input  logic [twc_pkg::POS_W-1:0]  in_read_position,
  input  logic [twc_pkg::CH_W-1:0]   in_read_channel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [twc_pkg::WORD_W-1:0] out_read_data,
  output logic [1:0]                 out_slot_status,
  output logic                       out_slot_wrapped,
  output logic                       out_slot_armed,
  output logic [twc_pkg::POS_W-1:0]  out_stop_position,
  output logic [twc_pkg::POS_W-1:0]  out_write_position,
  output logic [twc_pkg::CNT_W-1:0]  out_records_done
);

  localparam int PW     = $clog2(DEPTH);
  localparam int FW     = $clog2(DEPTH + 1);
  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW     = (twc_pkg::PTD_W > PW) ? twc_pkg::PTD_W : PW;
  localparam int ROW_W  = CHANNELS * SAMPLE_BITS;
  localparam int ADDR_W = SW + PW;
  localparam logic [TW:0]   DEPTH_T = (TW + 1)'(DEPTH);
  localparam logic [PW:0]   DEPTH_P = (PW + 1)'(DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  // post-trigger distance, reduced modulo DEPTH
  logic [TW-1:0] ptd_r;
  logic          ptd_busy;

  // current slot
  logic [PW-1:0]            wp_r, wp_nxt;
  logic [twc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]            cs_r, cs_nxt;
  logic                     cwrap_r, cwrap_nxt;
  logic                     carmed_r, carmed_nxt;
  logic [PW-1:0]            cstop_r, cstop_nxt;
  logic [FW-1:0]            cfill_r, cfill_nxt;

  // per-slot tables
  twc_pkg::slot_st_t st_state_r [SLOTS];
  logic              st_wrap_r  [SLOTS];
  logic              st_armed_r [SLOTS];
  logic [PW-1:0]     st_stop_r  [SLOTS];
  logic [FW-1:0]     st_fill_r  [SLOTS];

  // pending stage (waiting on store read data)
  logic                     p_valid_r;
  logic                     p_dok_r;
  logic [twc_pkg::CH_W-1:0] p_ch_r;
  twc_pkg::slot_st_t        p_status_r;
  logic                     p_wrap_r;
  logic                     p_armed_r;
  logic [twc_pkg::POS_W-1:0] p_stop_r;
  logic [twc_pkg::POS_W-1:0] p_wpos_r;
  logic [twc_pkg::CNT_W-1:0] p_cnt_r;

  // output register
  logic                      out_valid_r;
  logic [twc_pkg::WORD_W-1:0] out_data_r;
  twc_pkg::slot_st_t         out_status_r;
  logic                      out_wrap_r;
  logic                      out_armed_r;
  logic [twc_pkg::POS_W-1:0] out_stop_r;
  logic [twc_pkg::POS_W-1:0] out_wpos_r;
  logic [twc_pkg::CNT_W-1:0] out_cnt_r;

  logic        acc, p_move;
  twc_pkg::cmd_t cmd;
  logic        do_sample, do_trigger, do_read;
  logic [4:0]  rs_m;
  logic [SW-1:0] rsel, ns, port;
  logic [PW-1:0] wp_inc, wp_adv, pos_pw, stop_calc;
  logic          wrapped, close;
  logic [FW-1:0] fill_upd;
  logic [TW:0]   stop_sum;
  logic [PW+twc_pkg::POS_W-1:0] pos_ext;
  logic [PW+twc_pkg::POS_W-1:0] stop_ext, wpos_ext, rstop_ext;
  logic          pos_ok, ch_ok, dok;
  logic [twc_pkg::WORD_W-1:0] smp [twc_pkg::NUM_IN_CH];
  logic [ROW_W-1:0] wr_row, rd_row;
  logic [SAMPLE_BITS-1:0] word_sel;
  logic [twc_pkg::WORD_W-1:0] word_out;

  // ---------------- configuration ----------------
  assign ptd_busy = ({1'b0, ptd_r} >= DEPTH_T);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptd_r <= TW'(twc_pkg::PTD_RESET);
    end else if (cfg_wr_en) begin
      ptd_r <= TW'(cfg_wr_data);
    end else if (ptd_busy) begin
      ptd_r <= TW'({1'b0, ptd_r} - DEPTH_T);
    end
  end

  // ---------------- handshake ----------------
  assign p_move   = p_valid_r && (!out_valid_r || out_ready);
  assign in_ready = (!p_valid_r || p_move) && !ptd_busy;
  assign acc      = in_valid && in_ready;

  assign cmd        = twc_pkg::cmd_t'(in_cmd);
  assign do_sample  = acc && (cmd == twc_pkg::CMD_SAMPLE);
  assign do_trigger = acc && (cmd == twc_pkg::CMD_TRIGGER);
  assign do_read    = (cmd == twc_pkg::CMD_READ);

  // ---------------- slot arithmetic ----------------
  always_comb begin
    rs_m = {3'b0, in_read_slot};
    for (int i = 0; i < 4; i++) begin
      if (rs_m >= 5'(SLOTS)) begin
        rs_m = rs_m - 5'(SLOTS);
      end
    end
  end

  assign rsel = rs_m[SW-1:0];
  assign ns   = (cs_r == LAST_SLOT) ? '0 : cs_r + 1'b1;
  assign port = do_read ? rsel : ns;

  assign wp_inc   = wp_r + 1'b1;
  assign wrapped  = ({1'b0, wp_r} + 1'b1) == DEPTH_P;
  assign wp_adv   = wrapped ? '0 : wp_inc;
  assign fill_upd = (cfill_r == FW'(wp_r)) ? FW'({1'b0, wp_r} + 1'b1) : cfill_r;
  assign close    = carmed_r && (wp_adv == cstop_r);

  assign stop_sum  = (TW + 1)'(wp_r) + {1'b0, ptd_r};
  assign stop_calc = (stop_sum >= DEPTH_T) ? PW'(stop_sum - DEPTH_T) : PW'(stop_sum);

  always_comb begin
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    cs_nxt     = cs_r;
    cwrap_nxt  = cwrap_r;
    carmed_nxt = carmed_r;
    cstop_nxt  = cstop_r;
    cfill_nxt  = cfill_r;
    if (do_sample) begin
      if (close) begin
        wp_nxt     = '0;
        cnt_nxt    = cnt_r + 1'b1;
        cs_nxt     = ns;
        cwrap_nxt  = 1'b0;
        carmed_nxt = 1'b0;
        cstop_nxt  = '0;
        cfill_nxt  = (ns == cs_r) ? fill_upd : st_fill_r[port];
      end else begin
        wp_nxt    = wp_adv;
        cwrap_nxt = cwrap_r | wrapped;
        cfill_nxt = fill_upd;
      end
    end else if (do_trigger && !carmed_r) begin
      carmed_nxt = 1'b1;
      cstop_nxt  = stop_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      cnt_r    <= '0;
      cs_r     <= '0;
      cwrap_r  <= 1'b0;
      carmed_r <= 1'b0;
      cstop_r  <= '0;
      cfill_r  <= '0;
    end else begin
      wp_r     <= wp_nxt;
      cnt_r    <= cnt_nxt;
      cs_r     <= cs_nxt;
      cwrap_r  <= cwrap_nxt;
      carmed_r <= carmed_nxt;
      cstop_r  <= cstop_nxt;
      cfill_r  <= cfill_nxt;
    end
  end

  // slot tables: write-through of the current slot, open of the next one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        st_state_r[s] <= (s == 0) ? twc_pkg::ST_RECORDING : twc_pkg::ST_EMPTY;
        st_wrap_r[s]  <= 1'b0;
        st_armed_r[s] <= 1'b0;
        st_stop_r[s]  <= '0;
        st_fill_r[s]  <= '0;
      end
    end else if (do_sample) begin
      st_wrap_r[cs_r] <= cwrap_r | wrapped;
      st_fill_r[cs_r] <= fill_upd;
      if (close) begin
        st_state_r[cs_r] <= twc_pkg::ST_RECORDED;
        st_state_r[ns]   <= twc_pkg::ST_RECORDING;
        st_wrap_r[ns]    <= 1'b0;
        st_armed_r[ns]   <= 1'b0;
        st_stop_r[ns]    <= '0;
      end
    end else if (do_trigger && !carmed_r) begin
      st_armed_r[cs_r] <= 1'b1;
      st_stop_r[cs_r]  <= stop_calc;
    end
  end

  // ---------------- sample store ----------------
  assign smp[0] = in_sample_0;
  assign smp[1] = in_sample_1;
  assign smp[2] = in_sample_2;
  assign smp[3] = in_sample_3;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      wr_row[c*SAMPLE_BITS +: SAMPLE_BITS] = smp[c][SAMPLE_BITS-1:0];
    end
  end

  assign pos_ext = {{PW{1'b0}}, in_read_position};
  assign pos_pw  = pos_ext[PW-1:0];
  assign pos_ok  = pos_ext < (PW + twc_pkg::POS_W)'(DEPTH);
  assign ch_ok   = 32'(in_read_channel) < CHANNELS;
  assign dok     = pos_ok && ch_ok && ((FW + twc_pkg::POS_W)'(in_read_position) <
                   (FW + twc_pkg::POS_W)'(st_fill_r[port]));

  twc_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (ROW_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_sample),
    .wr_addr ({cs_r, wp_r}),
    .wr_data (wr_row),
    .rd_en   (acc && do_read && dok),
    .rd_addr ({rsel, pos_pw}),
    .rd_data (rd_row)
  );

  // ---------------- pending stage ----------------
  assign stop_ext  = {{twc_pkg::POS_W{1'b0}}, cstop_nxt};
  assign rstop_ext = {{twc_pkg::POS_W{1'b0}}, st_stop_r[port]};
  assign wpos_ext  = {{twc_pkg::POS_W{1'b0}}, wp_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (acc) begin
      p_valid_r <= 1'b1;
    end else if (p_move) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_ch_r   <= in_read_channel;
      p_wpos_r <= wpos_ext[twc_pkg::POS_W-1:0];
      p_cnt_r  <= cnt_nxt;
      if (do_read) begin
        p_dok_r    <= dok;
        p_status_r <= st_state_r[port];
        p_wrap_r   <= st_wrap_r[port];
        p_armed_r  <= st_armed_r[port];
        p_stop_r   <= rstop_ext[twc_pkg::POS_W-1:0];
      end else begin
        p_dok_r    <= 1'b0;
        p_status_r <= twc_pkg::ST_RECORDING;
        p_wrap_r   <= cwrap_nxt;
        p_armed_r  <= carmed_nxt;
        p_stop_r   <= stop_ext[twc_pkg::POS_W-1:0];
      end
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    word_sel = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (32'(p_ch_r) == c) begin
        word_sel = rd_row[c*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
  end

  assign word_out = twc_pkg::WORD_W'(word_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_data_r   <= p_dok_r ? word_out : '0;
      out_status_r <= p_status_r;
      out_wrap_r   <= p_wrap_r;
      out_armed_r  <= p_armed_r;
      out_stop_r   <= p_stop_r;
      out_wpos_r   <= p_wpos_r;
      out_cnt_r    <= p_cnt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_data_r;
  assign out_slot_status    = out_status_r;
  assign out_slot_wrapped   = out_wrap_r;
  assign out_slot_armed     = out_armed_r;
  assign out_stop_position  = out_stop_r;
  assign out_write_position = out_wpos_r;
  assign out_records_done   = out_cnt_r;

  // ---------------- assertions ----------------
  a_cur_recording: assert property (@(posedge clk) disable iff (!rst_n)
    st_state_r[cs_r] == twc_pkg::ST_RECORDING)
    else $error("current slot not in recording state");

  a_cur_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    st_armed_r[cs_r] == carmed_r && st_stop_r[cs_r] == cstop_r &&
    st_wrap_r[cs_r] == cwrap_r && st_fill_r[cs_r] == cfill_r)
    else $error("slot table out of step with current slot registers");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cfill_r >= FW'(wp_r) && {1'b0, cfill_r} <= (FW + 1)'(DEPTH))
    else $error("fill mark behind write pointer or beyond depth");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cs_r) < SLOTS && {1'b0, wp_r} < DEPTH_P)
    else $error("slot or write pointer out of range");

  a_close_advance: assert property (@(posedge clk) disable iff (!rst_n)
    do_sample && close |=> cnt_r == $past(cnt_r) + 1'b1 && wp_r == '0 && !carmed_r)
    else $error("record close did not open the next slot");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ptd_busy |-> !in_ready)
    else $error("input taken while trigger distance unreduced");

endmodule

// File: bench/tb_triggered_wave_capture.sv
`timescale 1ns / 1ps
// Self-checking bench for triggered_wave_capture: directed table, then random beats
// scored against an in-bench recorder model. Depends on twc_pkg and the block RTL.
module tb_triggered_wave_capture;

  localparam logic [twc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int DIR_N        = 15;
  localparam int CLOSE_PAIRS  = 16;

  typedef struct packed {
    logic [twc_pkg::CMD_W-1:0]  cmd;
    logic [twc_pkg::WORD_W-1:0] s0, s1, s2, s3;
    logic [twc_pkg::SLOT_W-1:0] rslot;
    logic [twc_pkg::POS_W-1:0]  rpos;
    logic [twc_pkg::CH_W-1:0]   rch;
  } beat_t;

  typedef struct packed {
    logic [twc_pkg::WORD_W-1:0] data;
    logic [1:0]                 status;
    logic                       wrapped;
    logic                       armed;
    logic [twc_pkg::POS_W-1:0]  stop;
    logic [twc_pkg::POS_W-1:0]  wpos;
    logic [twc_pkg::CNT_W-1:0]  done;
  } capture_t;

  typedef struct {
    beat_t    beat;
    bit       typed;
    capture_t want;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_COIN} rx_pattern_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [twc_pkg::PTD_W-1:0]  cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [twc_pkg::CMD_W-1:0]  in_cmd = '0;
  logic [twc_pkg::WORD_W-1:0] in_sample_0 = '0, in_sample_1 = '0;
  logic [twc_pkg::WORD_W-1:0] in_sample_2 = '0, in_sample_3 = '0;
  logic [twc_pkg::SLOT_W-1:0] in_read_slot = '0;
  logic [twc_pkg::POS_W-1:0]  in_read_position = '0;
  logic [twc_pkg::CH_W-1:0]   in_read_channel = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [twc_pkg::WORD_W-1:0] out_read_data;
  logic [1:0]                 out_slot_status;
  logic                       out_slot_wrapped;
  logic                       out_slot_armed;
  logic [twc_pkg::POS_W-1:0]  out_stop_position;
  logic [twc_pkg::POS_W-1:0]  out_write_position;
  logic [twc_pkg::CNT_W-1:0]  out_records_done;

  triggered_wave_capture dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_sample_0(in_sample_0), .in_sample_1(in_sample_1),
    .in_sample_2(in_sample_2), .in_sample_3(in_sample_3),
    .in_read_slot(in_read_slot), .in_read_position(in_read_position),
    .in_read_channel(in_read_channel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_data(out_read_data), .out_slot_status(out_slot_status),
    .out_slot_wrapped(out_slot_wrapped), .out_slot_armed(out_slot_armed),
    .out_stop_position(out_stop_position), .out_write_position(out_write_position),
    .out_records_done(out_records_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // recorder model state
  logic [twc_pkg::WORD_W-1:0] shadow_mem [twc_pkg::SLOTS_DEF][twc_pkg::DEPTH_DEF]
                                         [twc_pkg::CHANNELS_DEF];
  logic [1:0]                 shadow_status [twc_pkg::SLOTS_DEF];
  logic                       shadow_wrap [twc_pkg::SLOTS_DEF];
  logic                       shadow_armed [twc_pkg::SLOTS_DEF];
  logic [twc_pkg::POS_W-1:0]  shadow_stop [twc_pkg::SLOTS_DEF];
  int unsigned                shadow_wptr;
  logic [twc_pkg::CNT_W-1:0]  shadow_done;
  logic [twc_pkg::PTD_W-1:0]  shadow_ptd;

  capture_t    pending_captures[$];
  int unsigned error_count = 0;
  bit          sender_gaps = 1'b1;
  int          burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int          hold_left = 0;
  rx_pattern_t rx_mode = RX_OPEN;
  int unsigned rx_tick = 0;
  dir_row_t    dir_table [DIR_N];

  function automatic void open_record(int s);
    shadow_status[s] = twc_pkg::ST_RECORDING;
    shadow_armed[s]  = 1'b0;
    shadow_stop[s]   = '0;
    shadow_wrap[s]   = 1'b0;
    shadow_wptr      = 0;
  endfunction

  function automatic void clear_recorder();
    for (int s = 0; s < twc_pkg::SLOTS_DEF; s++) begin
      for (int p = 0; p < twc_pkg::DEPTH_DEF; p++)
        for (int c = 0; c < twc_pkg::CHANNELS_DEF; c++)
          shadow_mem[s][p][c] = '0;
      shadow_status[s] = twc_pkg::ST_EMPTY;
      shadow_wrap[s]   = 1'b0;
      shadow_armed[s]  = 1'b0;
      shadow_stop[s]   = '0;
    end
    shadow_done = '0;
    shadow_ptd  = twc_pkg::PTD_RESET;
    open_record(0);
  endfunction

  function automatic capture_t record_beat(beat_t b);
    capture_t r;
    int cur;
    int rep;
    r   = '0;
    cur = shadow_done % twc_pkg::SLOTS_DEF;
    rep = cur;
    case (b.cmd)
      twc_pkg::CMD_SAMPLE: begin
        shadow_mem[cur][shadow_wptr][0] = b.s0;
        shadow_mem[cur][shadow_wptr][1] = b.s1;
        shadow_mem[cur][shadow_wptr][2] = b.s2;
        shadow_mem[cur][shadow_wptr][3] = b.s3;
        shadow_wptr++;
        if (shadow_wptr >= twc_pkg::DEPTH_DEF) begin
          shadow_wptr      = 0;
          shadow_wrap[cur] = 1'b1;
        end
        if (shadow_armed[cur] && shadow_wptr == shadow_stop[cur]) begin
          shadow_status[cur] = twc_pkg::ST_RECORDED;
          shadow_done++;
          open_record(shadow_done % twc_pkg::SLOTS_DEF);
        end
        rep = shadow_done % twc_pkg::SLOTS_DEF;
      end
      twc_pkg::CMD_TRIGGER: begin
        if (!shadow_armed[cur]) begin
          shadow_armed[cur] = 1'b1;
          shadow_stop[cur]  = twc_pkg::POS_W'((shadow_wptr + shadow_ptd) %
                                              twc_pkg::DEPTH_DEF);
        end
      end
      twc_pkg::CMD_READ: begin
        rep    = b.rslot % twc_pkg::SLOTS_DEF;
        r.data = shadow_mem[rep][b.rpos][b.rch];
      end
      default: ;
    endcase
    r.status  = shadow_status[rep];
    r.wrapped = shadow_wrap[rep];
    r.armed   = shadow_armed[rep];
    r.stop    = shadow_armed[rep] ? shadow_stop[rep] : '0;
    r.wpos    = twc_pkg::POS_W'(shadow_wptr);
    r.done    = shadow_done;
    return r;
  endfunction

  function automatic beat_t mk_read(int slot, int pos, int ch);
    beat_t b;
    b       = '0;
    b.cmd   = twc_pkg::CMD_READ;
    b.rslot = twc_pkg::SLOT_W'(slot);
    b.rpos  = twc_pkg::POS_W'(pos);
    b.rch   = twc_pkg::CH_W'(ch);
    return b;
  endfunction

  function automatic beat_t mk_sample(logic [15:0] a, logic [15:0] b1, logic [15:0] c,
                                     logic [15:0] d);
    beat_t b;
    b     = '0;
    b.cmd = twc_pkg::CMD_SAMPLE;
    b.s0  = a;
    b.s1  = b1;
    b.s2  = c;
    b.s3  = d;
    return b;
  endfunction

  // non-sample command with every other field all zero or all one
  function automatic beat_t mk_cmd(logic [twc_pkg::CMD_W-1:0] cmd, bit fill);
    beat_t b;
    b     = fill ? '1 : '0;
    b.cmd = cmd;
    return b;
  endfunction

  function automatic capture_t mk_want(int data, logic [1:0] st, bit wr, bit arm, int stop,
                                       int wpos, int done);
    capture_t r;
    r.data    = twc_pkg::WORD_W'(data);
    r.status  = st;
    r.wrapped = wr;
    r.armed   = arm;
    r.stop    = twc_pkg::POS_W'(stop);
    r.wpos    = twc_pkg::POS_W'(wpos);
    r.done    = twc_pkg::CNT_W'(done);
    return r;
  endfunction

  function automatic beat_t random_beat(int pct_sample, int pct_trigger, int pct_read);
    beat_t b;
    int roll;
    b.s0    = twc_pkg::WORD_W'($urandom);
    b.s1    = twc_pkg::WORD_W'($urandom);
    b.s2    = twc_pkg::WORD_W'($urandom);
    b.s3    = twc_pkg::WORD_W'($urandom);
    b.rslot = twc_pkg::SLOT_W'($urandom);
    b.rpos  = twc_pkg::POS_W'($urandom);
    b.rch   = twc_pkg::CH_W'($urandom);
    roll    = $urandom_range(0, 99);
    if (roll < pct_sample) b.cmd = twc_pkg::CMD_SAMPLE;
    else if (roll < pct_sample + pct_trigger) b.cmd = twc_pkg::CMD_TRIGGER;
    else if (roll < pct_sample + pct_trigger + pct_read) b.cmd = twc_pkg::CMD_READ;
    else b.cmd = CMD_UNUSED;
    // half the reads aim at written positions, mostly in the current slot
    if (b.cmd == twc_pkg::CMD_READ && $urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 2) != 0)
        b.rslot = twc_pkg::SLOT_W'(shadow_done % twc_pkg::SLOTS_DEF);
      if (shadow_wptr > 0) b.rpos = twc_pkg::POS_W'($urandom_range(0, shadow_wptr - 1));
    end
    return b;
  endfunction

  // called at a falling edge; returns at a falling edge after the beat is taken
  task automatic send_beat(input beat_t b, input bit typed, input capture_t want);
    capture_t predicted;
    in_valid         <= 1'b1;
    in_cmd           <= b.cmd;
    in_sample_0      <= b.s0;
    in_sample_1      <= b.s1;
    in_sample_2      <= b.s2;
    in_sample_3      <= b.s3;
    in_read_slot     <= b.rslot;
    in_read_position <= b.rpos;
    in_read_channel  <= b.rch;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = record_beat(b);
    pending_captures.push_back(typed ? want : predicted);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else if (sender_gaps) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 24);
    end
  endtask

  task automatic send_random(int n, int pct_sample, int pct_trigger, int pct_read);
    for (int i = 0; i < n; i++)
      send_beat(random_beat(pct_sample, pct_trigger, pct_read), 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_captures.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_post_trigger(logic [twc_pkg::PTD_W-1:0] dots);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dots;
    shadow_ptd   = dots;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready <= (rx_tick % 4 == 0);
        default:   out_ready <= 1'($urandom_range(0, 1));
      endcase
      rx_tick <= rx_tick + 1;
      if (rx_tick % 50 == 49) rx_mode <= rx_pattern_t'($urandom_range(0, 3));
    end
  end

  always @(posedge clk) begin : score
    capture_t got;
    capture_t want;
    if (rst_n && out_valid && out_ready) begin
      got.data    = out_read_data;
      got.status  = out_slot_status;
      got.wrapped = out_slot_wrapped;
      got.armed   = out_slot_armed;
      got.stop    = out_stop_position;
      got.wpos    = out_write_position;
      got.done    = out_records_done;
      if (pending_captures.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected beat: data %h st %0d wr %0b arm %0b stop %0d wp %0d done %0d",
                   got.data, got.status, got.wrapped, got.armed, got.stop, got.wpos,
                   got.done);
      end else begin
        want = pending_captures.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch exp: data %h st %0d wr %0b arm %0b stop %0d wp %0d done %0d",
                     want.data, want.status, want.wrapped, want.armed, want.stop, want.wpos,
                     want.done);
            $display("         got: data %h st %0d wr %0b arm %0b stop %0d wp %0d done %0d",
                     got.data, got.status, got.wrapped, got.armed, got.stop, got.wpos,
                     got.done);
          end
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_triggered_wave_capture: done, errors");
    $finish;
  end

  initial begin
    dir_table[0]  = '{mk_read(0, 0, 0), 1'b1,
                      mk_want(0, twc_pkg::ST_RECORDING, 1'b0, 1'b0, 0, 0, 0)};
    dir_table[1]  = '{mk_read(3, 1023, 3), 1'b1,
                      mk_want(0, twc_pkg::ST_EMPTY, 1'b0, 1'b0, 0, 0, 0)};
    dir_table[2]  = '{mk_cmd(CMD_UNUSED, 1'b1), 1'b1,
                      mk_want(0, twc_pkg::ST_RECORDING, 1'b0, 1'b0, 0, 0, 0)};
    dir_table[3]  = '{mk_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff), 1'b1,
                      mk_want(0, twc_pkg::ST_RECORDING, 1'b0, 1'b0, 0, 1, 0)};
    dir_table[4]  = '{mk_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1,
                      mk_want(0, twc_pkg::ST_RECORDING, 1'b0, 1'b0, 0, 2, 0)};
    dir_table[5]  = '{mk_sample(16'haaaa, 16'h5555, 16'h0f0f, 16'hf0f0), 1'b1,
                      mk_want(0, twc_pkg::ST_RECORDING, 1'b0, 1'b0, 0, 3, 0)};
    dir_table[6]  = '{mk_read(0, 0, 3), 1'b1,
                      mk_want(16'hffff, twc_pkg::ST_RECORDING, 1'b0, 1'b0, 0, 3, 0)};
    dir_table[7]  = '{mk_read(0, 2, 1), 1'b1,
                      mk_want(16'h5555, twc_pkg::ST_RECORDING, 1'b0, 1'b0, 0, 3, 0)};
    // trigger at position 3 arms 3 + 160; the repeat is ignored
    dir_table[8]  = '{mk_cmd(twc_pkg::CMD_TRIGGER, 1'b0), 1'b1,
                      mk_want(0, twc_pkg::ST_RECORDING, 1'b0, 1'b1, 163, 3, 0)};
    dir_table[9]  = '{mk_cmd(twc_pkg::CMD_TRIGGER, 1'b1), 1'b1,
                      mk_want(0, twc_pkg::ST_RECORDING, 1'b0, 1'b1, 163, 3, 0)};
    dir_table[10] = '{mk_read(0, 1023, 0), 1'b1,
                      mk_want(0, twc_pkg::ST_RECORDING, 1'b0, 1'b1, 163, 3, 0)};
    dir_table[11] = '{mk_read(2, 512, 2), 1'b1,
                      mk_want(0, twc_pkg::ST_EMPTY, 1'b0, 1'b0, 0, 3, 0)};
    dir_table[12] = '{mk_cmd(CMD_UNUSED, 1'b0), 1'b1,
                      mk_want(0, twc_pkg::ST_RECORDING, 1'b0, 1'b1, 163, 3, 0)};
    dir_table[13] = '{mk_sample(16'h8000, 16'h0001, 16'h7fff, 16'hfffe), 1'b0, '0};
    dir_table[14] = '{mk_read(1, 1, 1), 1'b0, '0};

    clear_recorder();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_beat(dir_table[i].beat, dir_table[i].typed, dir_table[i].want);
    send_random(120, 60, 6, 30);

    // zero distance: the record closes after a full lap, which also wraps the slot
    set_post_trigger(10'd0);
    send_beat(mk_cmd(twc_pkg::CMD_TRIGGER, 1'b0), 1'b0, '0);
    send_random(1050, 99, 0, 1);

    set_post_trigger(10'd1023);
    send_beat(mk_cmd(twc_pkg::CMD_TRIGGER, 1'b1), 1'b0, '0);
    send_random(50, 70, 5, 20);

    // receiver holds off while the sender streams back to back
    set_post_trigger(twc_pkg::PTD_W'($urandom_range(2, 40)));
    sender_gaps = 1'b0;
    hold_requests++;
    send_random(100, 55, 10, 30);
    sender_gaps = 1'b1;

    // one record per trigger/sample pair, cycling through every slot
    set_post_trigger(10'd1);
    for (int i = 0; i < CLOSE_PAIRS; i++) begin
      send_beat(mk_cmd(twc_pkg::CMD_TRIGGER, 1'b0), 1'b0, '0);
      send_beat(random_beat(100, 0, 0), 1'b0, '0);
    end
    send_random(30, 50, 10, 35);

    set_post_trigger(twc_pkg::PTD_W'($urandom_range(0, 1023)));
    send_random(30, 60, 5, 30);

    drain();
    if (error_count == 0) begin
      $display("tb_triggered_wave_capture: done, clean");
    end else begin
      $display("tb_triggered_wave_capture: done, errors");
    end
    $finish;
  end

endmodule
